// ===== rtl/core/bilinear_sample_blend_core_assert.svh =====
// ----------------------------------------------------------------------------
// bilinear sample blend assertion macros
// shared concurrent assertion forms, clocked on clk, off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef BILINEAR_SAMPLE_BLEND_CORE_ASSERT_SVH
`define BILINEAR_SAMPLE_BLEND_CORE_ASSERT_SVH

// same-cycle implication
`define BSB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsb assertion failed");

// next-cycle implication
`define BSB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsb assertion failed");

`endif

// ===== rtl/core/bsb_pkg.sv =====
// ----------------------------------------------------------------------------
// bsb_pkg
// shared constants, types and width helpers of the bilinear sample blend core
// ----------------------------------------------------------------------------
package bsb_pkg;

	localparam int BSB_FRAC_BITS      = 8;
	localparam int BSB_MAX_IMAGES     = 16;
	localparam int BSB_COORD_INT_BITS = 16;
	localparam int BSB_QUEUE_DEPTH    = 2;

	typedef struct packed {
		logic full;
		logic empty;
	} bsb_q_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_ROUND,
		BK_OUT
	} bsb_bk_state_t;

	// accumulator width for the largest pixel sum
	function automatic int bsb_sum_w(int frac_bits, int max_images);
		longint unsigned top_val;
		top_val = (longint'(255) << (2 * frac_bits)) * longint'(max_images);
		return $clog2(top_val + 1);
	endfunction

	function automatic int bsb_cnt_w(int max_images);
		return $clog2(max_images + 1);
	endfunction

endpackage

// ===== rtl/core/bilinear_sample_blend_core.sv =====
// throughput: one item per cycle into the front while item_stall is low; the back
// divider takes the next sum only once the last result is handed off (8 quotient
// steps, one round, pop and hand-off); reset: asynchronous active low, clears sums, count, queue, blend_q and state
// ----------------------------------------------------------------------------
// bilinear_sample_blend_core
// per-pixel bilinear sampling and rgb average blend over source images
// ----------------------------------------------------------------------------
module bilinear_sample_blend_core import bsb_pkg::*; #(
	parameter int FRAC_BITS      = BSB_FRAC_BITS,
	parameter int MAX_IMAGES     = BSB_MAX_IMAGES,
	parameter int COORD_INT_BITS = BSB_COORD_INT_BITS
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic                                     cfg_wdata,
	input  logic                                     item_valid,
	output logic                                     item_stall,
	input  logic                                     ground_valid,
	input  logic                                     projected_ok,
	input  logic signed [COORD_INT_BITS+FRAC_BITS:0] sample_pos,
	input  logic signed [COORD_INT_BITS+FRAC_BITS:0] line_pos,
	input  logic [15:0]                              image_cols,
	input  logic [15:0]                              image_rows,
	input  logic [23:0]                              pixel_top_left,
	input  logic [23:0]                              pixel_top_right,
	input  logic [23:0]                              pixel_bottom_left,
	input  logic [23:0]                              pixel_bottom_right,
	input  logic                                     last_image,
	output logic                                     result_valid,
	input  logic                                     result_stall,
	output logic [7:0]                               blue,
	output logic [7:0]                               green,
	output logic [7:0]                               red,
	output logic                                     pixel_valid,
	output logic [4:0]                               contributor_count
);

	localparam int CNT_W = bsb_cnt_w(MAX_IMAGES);
	localparam int SUM_W = bsb_sum_w(FRAC_BITS, MAX_IMAGES);
	localparam int E_W   = CNT_W + 3 * SUM_W;

	bsb_q_stat_t    q_stat;
	logic           push, pop;
	logic [E_W-1:0] push_data, pop_data;

	bsb_front #(
		.FRAC_BITS      (FRAC_BITS),
		.MAX_IMAGES     (MAX_IMAGES),
		.COORD_INT_BITS (COORD_INT_BITS)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.item_valid         (item_valid),
		.item_stall         (item_stall),
		.ground_valid       (ground_valid),
		.projected_ok       (projected_ok),
		.sample_pos         (sample_pos),
		.line_pos           (line_pos),
		.image_cols         (image_cols),
		.image_rows         (image_rows),
		.pixel_top_left     (pixel_top_left),
		.pixel_top_right    (pixel_top_right),
		.pixel_bottom_left  (pixel_bottom_left),
		.pixel_bottom_right (pixel_bottom_right),
		.last_image         (last_image),
		.q_stat             (q_stat),
		.push               (push),
		.push_data          (push_data)
	);

	bsb_fifo #(
		.WIDTH (E_W),
		.DEPTH (BSB_QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	bsb_back #(
		.FRAC_BITS  (FRAC_BITS),
		.MAX_IMAGES (MAX_IMAGES)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_stat            (q_stat),
		.pop_data          (pop_data),
		.pop               (pop),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.blue              (blue),
		.green             (green),
		.red               (red),
		.pixel_valid       (pixel_valid),
		.contributor_count (contributor_count)
	);

endmodule

// ===== rtl/core/bsb_fifo.sv =====
// ----------------------------------------------------------------------------
// bsb_fifo
// short queue of finished pixel sums between front and back
// ----------------------------------------------------------------------------
`include "bilinear_sample_blend_core_assert.svh"

module bsb_fifo import bsb_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = BSB_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output bsb_q_stat_t      stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`BSB_ASSERT_NOW(a_no_overflow, push, !stat.full)
	`BSB_ASSERT_NOW(a_no_underflow, pop, !stat.empty)
	`BSB_ASSERT_NEXT(a_fill_up, push && !pop, count_q == CNT_W'($past(count_q) + 1'b1))
	`BSB_ASSERT_NEXT(a_fill_down, pop && !push, count_q == CNT_W'($past(count_q) - 1'b1))

endmodule

// ===== rtl/core/bsb_front.sv =====
// ----------------------------------------------------------------------------
// bsb_front
// classifies samples, interpolates them in two passes and accumulates sums
// ----------------------------------------------------------------------------
module bsb_front import bsb_pkg::*; #(
	parameter int FRAC_BITS      = BSB_FRAC_BITS,
	parameter int MAX_IMAGES     = BSB_MAX_IMAGES,
	parameter int COORD_INT_BITS = BSB_COORD_INT_BITS,
	localparam int POS_W = COORD_INT_BITS + FRAC_BITS + 1,
	localparam int CNT_W = bsb_cnt_w(MAX_IMAGES),
	localparam int SUM_W = bsb_sum_w(FRAC_BITS, MAX_IMAGES),
	localparam int E_W   = CNT_W + 3 * SUM_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic                    cfg_wdata,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic                    ground_valid,
	input  logic                    projected_ok,
	input  logic signed [POS_W-1:0] sample_pos,
	input  logic signed [POS_W-1:0] line_pos,
	input  logic [15:0]             image_cols,
	input  logic [15:0]             image_rows,
	input  logic [23:0]             pixel_top_left,
	input  logic [23:0]             pixel_top_right,
	input  logic [23:0]             pixel_bottom_left,
	input  logic [23:0]             pixel_bottom_right,
	input  logic                    last_image,
	input  bsb_q_stat_t             q_stat,
	output logic                    push,
	output logic [E_W-1:0]          push_data
);

	localparam int H_W   = FRAC_BITS + 8;
	localparam int V_W   = 2 * FRAC_BITS + 8;
	localparam int CMP_W = (POS_W - 1 > 16 + FRAC_BITS) ? POS_W - 1 : 16 + FRAC_BITS;
	localparam logic [FRAC_BITS:0] FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic                       blend_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       first_q;
	logic [2:0][SUM_W-1:0]      sums_q;

	logic                       v_s1, v_s2, v_s3;
	logic                       acc_s1, acc_s2, acc_s3;
	logic                       last_s1, last_s2, last_s3;
	logic [CNT_W-1:0]           cnt_s1, cnt_s2, cnt_s3;
	logic [FRAC_BITS-1:0]       dx_s1, dy_s1, dy_s2;
	logic [3:0][23:0]           px_s1;
	logic [2:0][H_W-1:0]        top_s2, bot_s2;
	logic [2:0][V_W-1:0]        vert_s3;

	logic                       adv, take, cand;
	logic [CNT_W-1:0]           cnt_nx;
	logic [FRAC_BITS:0]         wx0, wy0;
	logic [2:0][H_W:0]          hp0, hp1, hp2, hp3;
	logic [2:0][H_W:0]          hsum_t, hsum_b;
	logic [2:0][H_W-1:0]        top_nx, bot_nx;
	logic [2:0][V_W:0]          vp0, vp1, vsum;
	logic [2:0][V_W-1:0]        vert_nx;
	logic [2:0][SUM_W-1:0]      sum_nx;

	function automatic logic in_area(logic [POS_W-1:0] pos, logic [15:0] size);
		logic [CMP_W-1:0] mag;
		logic [CMP_W-1:0] lim;
		mag = CMP_W'(pos[POS_W-2:0]);
		lim = CMP_W'({size - 16'd1, {FRAC_BITS{1'b0}}});
		return !pos[POS_W-1] && (size != 16'd0) && (mag < lim);
	endfunction

	// the pipe halts only when a finished pixel cannot enter the queue
	assign adv        = !(v_s3 && last_s3 && q_stat.full);
	assign item_stall = !adv;
	assign take       = item_valid && adv;

	always_comb begin
		cand = ground_valid && projected_ok
			&& in_area(sample_pos, image_cols) && in_area(line_pos, image_rows)
			&& !(first_q && !blend_q)
			&& (cnt_q < CNT_W'(MAX_IMAGES));
		cnt_nx = cand ? CNT_W'(cnt_q + 1'b1) : cnt_q;
	end

	// horizontal then vertical pass, exact in units of 1/S^2
	always_comb begin
		wx0 = FRAC_ONE - {1'b0, dx_s1};
		wy0 = FRAC_ONE - {1'b0, dy_s2};
		for (int c = 0; c < 3; c++) begin
			hp0[c]     = (H_W+1)'(wx0) * (H_W+1)'(px_s1[0][8*c +: 8]);
			hp1[c]     = (H_W+1)'(dx_s1) * (H_W+1)'(px_s1[1][8*c +: 8]);
			hp2[c]     = (H_W+1)'(wx0) * (H_W+1)'(px_s1[2][8*c +: 8]);
			hp3[c]     = (H_W+1)'(dx_s1) * (H_W+1)'(px_s1[3][8*c +: 8]);
			hsum_t[c]  = hp0[c] + hp1[c];
			hsum_b[c]  = hp2[c] + hp3[c];
			top_nx[c]  = hsum_t[c][H_W-1:0];
			bot_nx[c]  = hsum_b[c][H_W-1:0];
			vp0[c]     = (V_W+1)'(wy0) * (V_W+1)'(top_s2[c]);
			vp1[c]     = (V_W+1)'(dy_s2) * (V_W+1)'(bot_s2[c]);
			vsum[c]    = vp0[c] + vp1[c];
			vert_nx[c] = vsum[c][V_W-1:0];
			sum_nx[c]  = sums_q[c] + (acc_s3 ? SUM_W'(vert_s3[c]) : '0);
		end
	end

	assign push      = adv && v_s3 && last_s3;
	assign push_data = {cnt_s3, sum_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q <= 1'b0;
			cnt_q   <= '0;
			first_q <= 1'b0;
			sums_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			if (cfg_we) begin
				blend_q <= cfg_wdata;
			end
			if (adv) begin
				v_s1 <= item_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
			end
			if (take) begin
				if (last_image) begin
					cnt_q   <= '0;
					first_q <= 1'b0;
				end else begin
					cnt_q   <= cnt_nx;
					first_q <= first_q || cand;
				end
			end
			if (adv && v_s3) begin
				if (last_s3) begin
					sums_q <= '0;
				end else begin
					sums_q <= sum_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_s1   <= cand;
			last_s1  <= last_image;
			cnt_s1   <= cnt_nx;
			dx_s1    <= sample_pos[FRAC_BITS-1:0];
			dy_s1    <= line_pos[FRAC_BITS-1:0];
			px_s1[0] <= pixel_top_left;
			px_s1[1] <= pixel_top_right;
			px_s1[2] <= pixel_bottom_left;
			px_s1[3] <= pixel_bottom_right;
		end
		if (adv) begin
			acc_s2  <= acc_s1;
			last_s2 <= last_s1;
			cnt_s2  <= cnt_s1;
			dy_s2   <= dy_s1;
			top_s2  <= top_nx;
			bot_s2  <= bot_nx;
			acc_s3  <= acc_s2;
			last_s3 <= last_s2;
			cnt_s3  <= cnt_s2;
			vert_s3 <= vert_nx;
		end
	end

endmodule

// ===== rtl/core/bsb_back.sv =====
// ----------------------------------------------------------------------------
// bsb_back
// divides the pixel sums by the scaled count, rounds half to even, holds result
// ----------------------------------------------------------------------------
module bsb_back import bsb_pkg::*; #(
	parameter int FRAC_BITS  = BSB_FRAC_BITS,
	parameter int MAX_IMAGES = BSB_MAX_IMAGES,
	localparam int CNT_W = bsb_cnt_w(MAX_IMAGES),
	localparam int SUM_W = bsb_sum_w(FRAC_BITS, MAX_IMAGES),
	localparam int E_W   = CNT_W + 3 * SUM_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  bsb_q_stat_t    q_stat,
	input  logic [E_W-1:0] pop_data,
	output logic           pop,
	output logic           result_valid,
	input  logic           result_stall,
	output logic [7:0]     blue,
	output logic [7:0]     green,
	output logic [7:0]     red,
	output logic           pixel_valid,
	output logic [4:0]     contributor_count
);

	localparam int D0_W = CNT_W + 2 * FRAC_BITS;
	localparam int D_W  = D0_W + 7;
	localparam int CW   = (SUM_W > D_W) ? SUM_W : D_W;
	localparam int RW   = (SUM_W + 1 > D0_W) ? SUM_W + 1 : D0_W;

	bsb_bk_state_t         state_q, state_nx;
	logic [2:0]            step_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [2:0][SUM_W-1:0] rem_q;
	logic [2:0][7:0]       quo_q;
	logic [D_W-1:0]        dsh_q;
	logic [2:0][7:0]       res_q;
	logic                  pix_valid_q;
	logic [4:0]            count_q;

	logic                  load, div_en, rnd_en;
	logic [2:0]            ge;
	logic [2:0][SUM_W-1:0] rem_nx;
	logic [2:0][CW-1:0]    diff;
	logic [RW-1:0]         den_r;
	logic [2:0][RW-1:0]    rem2;
	logic [2:0]            up;
	logic [2:0][7:0]       rnd;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					state_nx = BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == 3'd7) begin
					state_nx = BK_ROUND;
				end
			end
			BK_ROUND: begin
				state_nx = BK_OUT;
			end
			BK_OUT: begin
				if (!result_stall) begin
					state_nx = BK_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		load         = (state_q == BK_IDLE) && !q_stat.empty;
		pop          = load;
		div_en       = (state_q == BK_DIV);
		rnd_en       = (state_q == BK_ROUND);
		result_valid = (state_q == BK_OUT);
	end

	// one quotient bit per cycle for each channel
	always_comb begin
		den_r = RW'({cnt_q, {(2 * FRAC_BITS){1'b0}}});
		for (int c = 0; c < 3; c++) begin
			ge[c]     = CW'(rem_q[c]) >= CW'(dsh_q);
			diff[c]   = CW'(rem_q[c]) - CW'(dsh_q);
			rem_nx[c] = ge[c] ? diff[c][SUM_W-1:0] : rem_q[c];
			rem2[c]   = RW'({rem_q[c], 1'b0});
			up[c]     = (rem2[c] > den_r) || ((rem2[c] == den_r) && quo_q[c][0]);
			rnd[c]    = (up[c] && (quo_q[c] != 8'd255)) ? quo_q[c] + 8'd1 : quo_q[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (load) begin
				step_q <= '0;
			end else if (div_en) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cnt_q <= pop_data[E_W-1 -: CNT_W];
			rem_q <= pop_data[3*SUM_W-1:0];
			dsh_q <= {pop_data[E_W-1 -: CNT_W], {(2 * FRAC_BITS + 7){1'b0}}};
		end else if (div_en) begin
			rem_q <= rem_nx;
			dsh_q <= dsh_q >> 1;
			for (int c = 0; c < 3; c++) begin
				quo_q[c] <= {quo_q[c][6:0], ge[c]};
			end
		end
		if (rnd_en) begin
			res_q       <= (cnt_q == '0) ? '0 : rnd;
			pix_valid_q <= (cnt_q != '0);
			count_q     <= 5'(cnt_q);
		end
	end

	assign blue              = res_q[0];
	assign green             = res_q[1];
	assign red               = res_q[2];
	assign pixel_valid       = pix_valid_q;
	assign contributor_count = count_q;

endmodule
